@@ rtl/lms_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, register indexes and pipeline payload types of the leg
// motion step unit. No dependencies.
package lms_pkg;

   localparam int LMS_FRAC_BITS = 16;

   localparam int VEL_W    = 31;   // velocity / lift height registers
   localparam int POS_W    = 32;   // positions
   localparam int TS_W     = 24;   // time step
   localparam int DIFF_W   = 33;   // position differences and their magnitudes
   localparam int LIFT_W   = 34;   // dz plus lift height
   localparam int RAD_W    = 66;   // sums of squares
   localparam int ROOT_W   = 33;   // square roots
   localparam int PROD_W   = 55;   // velocity * time step
   localparam int DUR_W    = 63;   // durations, capped at 2^62
   localparam int MULDIV_W = 94;   // lift height * duration
   localparam int CSR_IDX_W = 2;

   localparam logic [DUR_W-1:0] DUR_MAX = DUR_W'(1) << 62;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANAR_VEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFT_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFT_VEL    = 2'd2;

   // Travels beside the two square roots.
   typedef struct packed {
      logic [POS_W-1:0]  cx;
      logic [POS_W-1:0]  cy;
      logic [POS_W-1:0]  cz;
      logic [POS_W-1:0]  tz;
      logic [DIFF_W-1:0] mx;
      logic [DIFF_W-1:0] my;
      logic              neg_x;
      logic              neg_y;
      logic [DIFF_W-1:0] dz;
      logic [PROD_W-1:0] pv_ts;
      logic [PROD_W-1:0] lv_ts;
   } lms_front_type;

   // Travels beside the planar and duration dividers.
   typedef struct packed {
      logic [POS_W-1:0]  cx;
      logic [POS_W-1:0]  cy;
      logic [POS_W-1:0]  cz;
      logic [POS_W-1:0]  tz;
      logic              neg_x;
      logic              neg_y;
      logic              d2_zero;
      logic [PROD_W-1:0] lv_ts;
      logic [POS_W-1:0]  dist3d;
   } lms_mid_type;

   // Travels beside the lift scaling divider.
   typedef struct packed {
      logic [POS_W-1:0]  nx;
      logic [POS_W-1:0]  ny;
      logic [POS_W-1:0]  cz;
      logic [POS_W-1:0]  tz;
      logic [PROD_W-1:0] lv_ts;
      logic [POS_W-1:0]  dist3d;
      logic              h_div;
   } lms_tail_type;

endpackage

@@ rtl/lms_front.sv @@
`timescale 1ns / 1ps
// Front end: transaction capture, differences, speed * time step products,
// squares and sums of squares. Depends on lms_pkg.
module lms_front import lms_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          vld_i,
   input  logic [POS_W-1:0]              cx_i,
   input  logic [POS_W-1:0]              cy_i,
   input  logic [POS_W-1:0]              cz_i,
   input  logic [POS_W-1:0]              tx_i,
   input  logic [POS_W-1:0]              ty_i,
   input  logic [POS_W-1:0]              tz_i,
   input  logic [TS_W-1:0]               ts_i,
   input  logic [VEL_W-1:0]              pv_i,
   input  logic [VEL_W-1:0]              lv_i,
   output logic                          vld_o,
   output logic [1:0][RAD_W-1:0]         rad_o,
   output lms_front_type                 pay_o
);

   // stage 1: capture
   logic             v1_ff;
   logic [POS_W-1:0] cx_ff, cy_ff, cz_ff, tx_ff, ty_ff, tz_ff;
   logic [TS_W-1:0]  ts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= vld_i;
      end
      cx_ff <= cx_i;
      cy_ff <= cy_i;
      cz_ff <= cz_i;
      tx_ff <= tx_i;
      ty_ff <= ty_i;
      tz_ff <= tz_i;
      ts_ff <= ts_i;
   end

   // stage 2: differences, magnitudes, speed * time step
   logic              v2_ff;
   lms_front_type     p2_in, p2_ff;
   logic [DIFF_W-1:0] dx, dy, mz_in, mz2_ff;

   always_comb begin
      dx = {tx_ff[POS_W-1], tx_ff} - {cx_ff[POS_W-1], cx_ff};
      dy = {ty_ff[POS_W-1], ty_ff} - {cy_ff[POS_W-1], cy_ff};
      p2_in.cx    = cx_ff;
      p2_in.cy    = cy_ff;
      p2_in.cz    = cz_ff;
      p2_in.tz    = tz_ff;
      p2_in.dz    = {tz_ff[POS_W-1], tz_ff} - {cz_ff[POS_W-1], cz_ff};
      p2_in.neg_x = dx[DIFF_W-1];
      p2_in.neg_y = dy[DIFF_W-1];
      p2_in.mx    = dx[DIFF_W-1] ? -dx : dx;
      p2_in.my    = dy[DIFF_W-1] ? -dy : dy;
      mz_in       = p2_in.dz[DIFF_W-1] ? -p2_in.dz : p2_in.dz;
      p2_in.pv_ts = PROD_W'(pv_i) * PROD_W'(ts_ff);
      p2_in.lv_ts = PROD_W'(lv_i) * PROD_W'(ts_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      p2_ff  <= p2_in;
      mz2_ff <= mz_in;
   end

   // stage 3: squares
   logic             v3_ff;
   lms_front_type    p3_ff;
   logic [RAD_W-1:0] sqx_ff, sqy_ff, sqz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      p3_ff  <= p2_ff;
      sqx_ff <= RAD_W'(p2_ff.mx) * RAD_W'(p2_ff.mx);
      sqy_ff <= RAD_W'(p2_ff.my) * RAD_W'(p2_ff.my);
      sqz_ff <= RAD_W'(mz2_ff) * RAD_W'(mz2_ff);
   end

   // stage 4: planar and spatial sums
   logic             v4_ff;
   lms_front_type    p4_ff;
   logic [RAD_W-1:0] s2_in, s2_ff, s3_ff;

   assign s2_in = sqx_ff + sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      p4_ff <= p3_ff;
      s2_ff <= s2_in;
      s3_ff <= s2_in + sqz_ff;
   end

   assign vld_o    = v4_ff;
   assign rad_o[0] = s2_ff;
   assign rad_o[1] = s3_ff;
   assign pay_o    = p4_ff;

endmodule

@@ rtl/lms_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, several lanes.
// Depends on nothing.
module lms_sqrt #(
   parameter int LANES = 2,
   parameter int IN_W  = 66,
   parameter int PW    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        vld_i,
   input  logic [LANES-1:0][IN_W-1:0]  rad_i,
   input  logic [PW-1:0]               pay_i,
   output logic                        vld_o,
   output logic [LANES-1:0][IN_W/2-1:0] root_o,
   output logic [PW-1:0]               pay_o
);

   localparam int RW    = IN_W / 2;
   localparam int REM_W = RW + 2;

   logic                        vld_ff  [RW];
   logic [LANES-1:0][IN_W-1:0]  rad_ff  [RW];
   logic [LANES-1:0][REM_W-1:0] rem_ff  [RW];
   logic [LANES-1:0][RW-1:0]    root_ff [RW];
   logic [PW-1:0]               pay_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic                        vld_src;
      logic [LANES-1:0][IN_W-1:0]  rad_src;
      logic [LANES-1:0][REM_W-1:0] rem_src;
      logic [LANES-1:0][RW-1:0]    root_src;
      logic [PW-1:0]               pay_src;
      logic [LANES-1:0][REM_W-1:0] shifted;
      logic [LANES-1:0][REM_W-1:0] trial;
      logic [LANES-1:0][REM_W-1:0] rem_in;
      logic [LANES-1:0][RW-1:0]    root_in;

      if (k == 0) begin : g_load
         assign vld_src  = vld_i;
         assign rad_src  = rad_i;
         assign rem_src  = '0;
         assign root_src = '0;
         assign pay_src  = pay_i;
      end else begin : g_link
         assign vld_src  = vld_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign pay_src  = pay_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            shifted[l] = {rem_src[l][REM_W-3:0], rad_src[l][2*(RW-1-k)+1 -: 2]};
            trial[l]   = {root_src[l], 2'b01};
            if (shifted[l] >= trial[l]) begin
               rem_in[l]  = shifted[l] - trial[l];
               root_in[l] = (root_src[l] << 1) | RW'(1);
            end else begin
               rem_in[l]  = shifted[l];
               root_in[l] = root_src[l] << 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rad_ff[k]  <= rad_src;
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         pay_ff[k]  <= pay_src;
      end
   end

   assign vld_o  = vld_ff[RW-1];
   assign root_o = root_ff[RW-1];
   assign pay_o  = pay_ff[RW-1];

endmodule

@@ rtl/lms_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// The dividend bits above QW must be below the divisor. Depends on nothing.
module lms_div #(
   parameter int LANES  = 1,
   parameter int DEND_W = 8,
   parameter int DSOR_W = 8,
   parameter int QW     = 8,
   parameter int PW     = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          vld_i,
   input  logic [LANES-1:0][DEND_W-1:0]  dend_i,
   input  logic [LANES-1:0][DSOR_W-1:0]  dsor_i,
   input  logic [PW-1:0]                 pay_i,
   output logic                          vld_o,
   output logic [LANES-1:0][QW-1:0]      quo_o,
   output logic [PW-1:0]                 pay_o
);

   localparam int HI_W  = DEND_W - QW;
   localparam int REM_W = DSOR_W + 1;

   logic                         vld_ff  [QW];
   logic [LANES-1:0][DEND_W-1:0] dend_ff [QW];
   logic [LANES-1:0][DSOR_W-1:0] dsor_ff [QW];
   logic [LANES-1:0][REM_W-1:0]  rem_ff  [QW];
   logic [LANES-1:0][QW-1:0]     quo_ff  [QW];
   logic [PW-1:0]                pay_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic                         vld_src;
      logic [LANES-1:0][DEND_W-1:0] dend_src;
      logic [LANES-1:0][DSOR_W-1:0] dsor_src;
      logic [LANES-1:0][REM_W-1:0]  rem_src;
      logic [LANES-1:0][QW-1:0]     quo_src;
      logic [PW-1:0]                pay_src;
      logic [LANES-1:0][REM_W-1:0]  shifted;
      logic [LANES-1:0][REM_W-1:0]  rem_in;
      logic [LANES-1:0][QW-1:0]     quo_in;

      if (k == 0) begin : g_load
         assign vld_src  = vld_i;
         assign dend_src = dend_i;
         assign dsor_src = dsor_i;
         assign quo_src  = '0;
         assign pay_src  = pay_i;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            if (HI_W > 0) begin : g_hi
               assign rem_src[l] = REM_W'(dend_i[l][DEND_W-1:QW]);
            end else begin : g_zero
               assign rem_src[l] = '0;
            end
         end
      end else begin : g_link
         assign vld_src  = vld_ff[k-1];
         assign dend_src = dend_ff[k-1];
         assign dsor_src = dsor_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign pay_src  = pay_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            shifted[l] = {rem_src[l][REM_W-2:0], dend_src[l][QW-1-k]};
            if (shifted[l] >= {1'b0, dsor_src[l]}) begin
               rem_in[l] = shifted[l] - {1'b0, dsor_src[l]};
               quo_in[l] = (quo_src[l] << 1) | QW'(1);
            end else begin
               rem_in[l] = shifted[l];
               quo_in[l] = quo_src[l] << 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         dend_ff[k] <= dend_src;
         dsor_ff[k] <= dsor_src;
         rem_ff[k]  <= rem_in;
         quo_ff[k]  <= quo_in;
         pay_ff[k]  <= pay_src;
      end
   end

   assign vld_o = vld_ff[QW-1];
   assign quo_o = quo_ff[QW-1];
   assign pay_o = pay_ff[QW-1];

endmodule

@@ rtl/lms_back.sv @@
`timescale 1ns / 1ps
// Back end: target height with scaled lift, Z step with saturation, and the
// result registers. Depends on lms_pkg.
module lms_back import lms_pkg::*; #(
   parameter int FRAC_BITS = LMS_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              vld_i,
   input  logic [VEL_W-1:0]  quo_i,
   input  lms_tail_type      pay_i,
   input  logic [VEL_W-1:0]  lh_i,
   output logic              valid_o,
   output logic [POS_W-1:0]  next_x_o,
   output logic [POS_W-1:0]  next_y_o,
   output logic [POS_W-1:0]  next_z_o,
   output logic [POS_W-1:0]  dist_o
);

   localparam int GAP_W = LIFT_W + 1;
   localparam int NZ_W  = LIFT_W + 2;
   localparam logic signed [NZ_W-1:0] Z_MAX = NZ_W'(64'sd2147483647);
   localparam logic signed [NZ_W-1:0] Z_MIN = -NZ_W'(64'sd2147483648);

   // F1: target height plus lift
   logic              f1_vld_ff;
   logic [VEL_W-1:0]  calc_h;
   logic [LIFT_W-1:0] th_ff;
   logic [PROD_W-1:0] lvz_ff;
   logic [POS_W-1:0]  f1_cz_ff, f1_nx_ff, f1_ny_ff, f1_d3_ff;

   assign calc_h = pay_i.h_div ? quo_i : lh_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= vld_i;
      end
      th_ff    <= {{2{pay_i.tz[POS_W-1]}}, pay_i.tz} + LIFT_W'(calc_h);
      lvz_ff   <= pay_i.lv_ts >> FRAC_BITS;
      f1_cz_ff <= pay_i.cz;
      f1_nx_ff <= pay_i.nx;
      f1_ny_ff <= pay_i.ny;
      f1_d3_ff <= pay_i.dist3d;
   end

   // F2: signed gap to the height target
   logic              f2_vld_ff;
   logic [GAP_W-1:0]  diff;
   logic [GAP_W-1:0]  gap_ff;
   logic              up_ff, down_ff;
   logic [PROD_W-1:0] f2_lvz_ff;
   logic [POS_W-1:0]  f2_cz_ff, f2_nx_ff, f2_ny_ff, f2_d3_ff;

   assign diff = {th_ff[LIFT_W-1], th_ff} - {{3{f1_cz_ff[POS_W-1]}}, f1_cz_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_vld_ff <= 1'b0;
      end else begin
         f2_vld_ff <= f1_vld_ff;
      end
      gap_ff    <= diff[GAP_W-1] ? -diff : diff;
      down_ff   <= diff[GAP_W-1];
      up_ff     <= !diff[GAP_W-1] && (diff != '0);
      f2_lvz_ff <= lvz_ff;
      f2_cz_ff  <= f1_cz_ff;
      f2_nx_ff  <= f1_nx_ff;
      f2_ny_ff  <= f1_ny_ff;
      f2_d3_ff  <= f1_d3_ff;
   end

   // F3: limited Z step, saturation, result registers
   logic                   valid_ff;
   logic [POS_W-1:0]       nx_ff, ny_ff, nz_ff, d3_ff;
   logic [GAP_W-1:0]       mz;
   logic signed [NZ_W-1:0] cz_ext, nz;
   logic [POS_W-1:0]       nz_in;

   always_comb begin
      mz     = (PROD_W'(gap_ff) < f2_lvz_ff) ? gap_ff : f2_lvz_ff[GAP_W-1:0];
      cz_ext = NZ_W'($signed(f2_cz_ff));
      if (up_ff) begin
         nz = cz_ext + $signed(NZ_W'(mz));
      end else if (down_ff) begin
         nz = cz_ext - $signed(NZ_W'(mz));
      end else begin
         nz = cz_ext;
      end
      if (nz > Z_MAX) begin
         nz_in = Z_MAX[POS_W-1:0];
      end else if (nz < Z_MIN) begin
         nz_in = Z_MIN[POS_W-1:0];
      end else begin
         nz_in = nz[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= f2_vld_ff;
      end
      nx_ff <= f2_nx_ff;
      ny_ff <= f2_ny_ff;
      nz_ff <= nz_in;
      d3_ff <= f2_d3_ff;
   end

   assign valid_o  = valid_ff;
   assign next_x_o = nx_ff;
   assign next_y_o = ny_ff;
   assign next_z_o = nz_ff;
   assign dist_o   = d3_ff;

endmodule

@@ rtl/leg_motion_step_unit.sv @@
`timescale 1ns / 1ps
// Top level of the leg motion step unit: configuration registers, step and
// duration stages between the arithmetic pipelines. Depends on lms_pkg and
// lms_front, lms_sqrt, lms_div, lms_back.
//
//  channel   ports                         handshake
//  request   start, busy, req_*            taken when start && !busy
//  response  rsp_valid, rsp_*              one-cycle strobe, no back-pressure
//  config    csr_we, csr_index, csr_wdata  written when csr_we
//
// One transaction enters per clock; busy is always low. The pipeline has
// 4 front stages, 33 square root stages, 2 step stages, 66 stages of the
// planar/duration divider with FRAC_BITS up to 33, 3 lift stages, 31
// stages of the lift divider and 3 Z stages. Reset clears the valid bits
// and loads the register defaults; there is no clearing pass.
module leg_motion_step_unit import lms_pkg::*; #(
   parameter int FRAC_BITS = LMS_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [POS_W-1:0]     req_current_x,
   input  logic [POS_W-1:0]     req_current_y,
   input  logic [POS_W-1:0]     req_current_z,
   input  logic [POS_W-1:0]     req_target_x,
   input  logic [POS_W-1:0]     req_target_y,
   input  logic [POS_W-1:0]     req_target_z,
   input  logic [TS_W-1:0]      req_time_step,
   output logic                 rsp_valid,
   output logic [POS_W-1:0]     rsp_next_x,
   output logic [POS_W-1:0]     rsp_next_y,
   output logic [POS_W-1:0]     rsp_next_z,
   output logic [POS_W-1:0]     rsp_distance_left,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VEL_W-1:0]     csr_wdata
);

   localparam int DIV_W = (RAD_W > ROOT_W + FRAC_BITS) ? RAD_W : ROOT_W + FRAC_BITS;
   localparam logic [VEL_W-1:0] VEL_RESET = VEL_W'(64'd1 << FRAC_BITS);

   // configuration registers
   logic [VEL_W-1:0] pv_ff, lh_ff, lv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= VEL_RESET;
         lh_ff <= '0;
         lv_ff <= VEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLANAR_VEL: begin
               pv_ff <= csr_wdata;
            end
            CSR_LIFT_HEIGHT: begin
               lh_ff <= csr_wdata;
            end
            CSR_LIFT_VEL: begin
               lv_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign busy = 1'b0;

   // front end and square roots
   logic                  fr_vld;
   logic [1:0][RAD_W-1:0] fr_rad;
   lms_front_type         fr_pay;

   lms_front u_front (
      .clock (clock),
      .reset (reset),
      .vld_i (start),
      .cx_i  (req_current_x),
      .cy_i  (req_current_y),
      .cz_i  (req_current_z),
      .tx_i  (req_target_x),
      .ty_i  (req_target_y),
      .tz_i  (req_target_z),
      .ts_i  (req_time_step),
      .pv_i  (pv_ff),
      .lv_i  (lv_ff),
      .vld_o (fr_vld),
      .rad_o (fr_rad),
      .pay_o (fr_pay)
   );

   logic                   sq_vld;
   logic [1:0][ROOT_W-1:0] sq_root;
   lms_front_type          sq_pay;

   lms_sqrt #(
      .LANES (2),
      .IN_W  (RAD_W),
      .PW    ($bits(lms_front_type))
   ) u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (fr_vld),
      .rad_i  (fr_rad),
      .pay_i  (fr_pay),
      .vld_o  (sq_vld),
      .root_o (sq_root),
      .pay_o  (sq_pay)
   );

   // M1: planar step limit, duration numerators
   logic              m1_vld_ff;
   logic [PROD_W-1:0] pv_step;
   logic [LIFT_W-1:0] lift_d, lift_m;
   logic [ROOT_W-1:0] step_ff, m1_d2_ff;
   logic [DIV_W-1:0]  nrem_ff, nlift_ff, nlow_ff;
   logic [POS_W-1:0]  m1_d3_ff;
   lms_front_type     m1_pay_ff;

   always_comb begin
      pv_step = sq_pay.pv_ts >> FRAC_BITS;
      lift_d  = {sq_pay.dz[DIFF_W-1], sq_pay.dz} + LIFT_W'(lh_ff);
      lift_m  = lift_d[LIFT_W-1] ? -lift_d : lift_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= sq_vld;
      end
      step_ff   <= (pv_step < PROD_W'(sq_root[0])) ? pv_step[ROOT_W-1:0] : sq_root[0];
      m1_d2_ff  <= sq_root[0];
      nrem_ff   <= DIV_W'(sq_root[0]) << FRAC_BITS;
      nlift_ff  <= DIV_W'(lift_m[DIFF_W-1:0]) << FRAC_BITS;
      nlow_ff   <= DIV_W'(lh_ff) << FRAC_BITS;
      m1_d3_ff  <= sq_root[1][ROOT_W-1] ? '1 : sq_root[1][POS_W-1:0];
      m1_pay_ff <= sq_pay;
   end

   // M2: per-axis products for the planar split
   logic             m2_vld_ff;
   logic [RAD_W-1:0] px_ff, py_ff;
   logic [ROOT_W-1:0] m2_d2_ff;
   logic [DIV_W-1:0] m2_nrem_ff, m2_nlift_ff, m2_nlow_ff;
   lms_mid_type      m2_pay_in, m2_pay_ff;

   always_comb begin
      m2_pay_in.cx      = m1_pay_ff.cx;
      m2_pay_in.cy      = m1_pay_ff.cy;
      m2_pay_in.cz      = m1_pay_ff.cz;
      m2_pay_in.tz      = m1_pay_ff.tz;
      m2_pay_in.neg_x   = m1_pay_ff.neg_x;
      m2_pay_in.neg_y   = m1_pay_ff.neg_y;
      m2_pay_in.d2_zero = (m1_d2_ff == '0);
      m2_pay_in.lv_ts   = m1_pay_ff.lv_ts;
      m2_pay_in.dist3d  = m1_d3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else begin
         m2_vld_ff <= m1_vld_ff;
      end
      px_ff       <= RAD_W'(m1_pay_ff.mx) * RAD_W'(step_ff);
      py_ff       <= RAD_W'(m1_pay_ff.my) * RAD_W'(step_ff);
      m2_d2_ff    <= m1_d2_ff;
      m2_nrem_ff  <= nrem_ff;
      m2_nlift_ff <= nlift_ff;
      m2_nlow_ff  <= nlow_ff;
      m2_pay_ff   <= m2_pay_in;
   end

   // lanes: X part, Y part, remaining planar time, lift time, lower time
   logic [4:0][DIV_W-1:0]  d1_dend;
   logic [4:0][ROOT_W-1:0] d1_dsor;
   logic                   d1_vld;
   logic [4:0][DIV_W-1:0]  d1_quo;
   lms_mid_type            d1_pay;

   always_comb begin
      d1_dend[0] = DIV_W'(px_ff);
      d1_dend[1] = DIV_W'(py_ff);
      d1_dend[2] = m2_nrem_ff;
      d1_dend[3] = m2_nlift_ff;
      d1_dend[4] = m2_nlow_ff;
      d1_dsor[0] = m2_d2_ff;
      d1_dsor[1] = m2_d2_ff;
      d1_dsor[2] = ROOT_W'(pv_ff);
      d1_dsor[3] = ROOT_W'(lv_ff);
      d1_dsor[4] = ROOT_W'(lv_ff);
   end

   lms_div #(
      .LANES  (5),
      .DEND_W (DIV_W),
      .DSOR_W (ROOT_W),
      .QW     (DIV_W),
      .PW     ($bits(lms_mid_type))
   ) u_div_main (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (m2_vld_ff),
      .dend_i (d1_dend),
      .dsor_i (d1_dsor),
      .pay_i  (m2_pay_ff),
      .vld_o  (d1_vld),
      .quo_o  (d1_quo),
      .pay_o  (d1_pay)
   );

   // P1: planar result, durations with the zero-speed cap
   logic              p1_vld_ff;
   logic [POS_W-1:0]  nx_in, ny_in;
   logic [POS_W-1:0]  p1_nx_ff, p1_ny_ff, p1_cz_ff, p1_tz_ff, p1_d3_ff;
   logic [DUR_W-1:0]  rem_ff, lift_ff, low_ff;
   logic [PROD_W-1:0] p1_lv_ts_ff;

   always_comb begin
      nx_in = d1_pay.neg_x ? d1_pay.cx - d1_quo[0][POS_W-1:0]
                           : d1_pay.cx + d1_quo[0][POS_W-1:0];
      ny_in = d1_pay.neg_y ? d1_pay.cy - d1_quo[1][POS_W-1:0]
                           : d1_pay.cy + d1_quo[1][POS_W-1:0];
      if (d1_pay.d2_zero) begin
         nx_in = d1_pay.cx;
         ny_in = d1_pay.cy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= d1_vld;
      end
      p1_nx_ff    <= nx_in;
      p1_ny_ff    <= ny_in;
      rem_ff      <= (pv_ff == '0) ? DUR_MAX : d1_quo[2][DUR_W-1:0];
      lift_ff     <= (lv_ff == '0) ? DUR_MAX : d1_quo[3][DUR_W-1:0];
      low_ff      <= (lv_ff == '0) ? DUR_MAX : d1_quo[4][DUR_W-1:0];
      p1_cz_ff    <= d1_pay.cz;
      p1_tz_ff    <= d1_pay.tz;
      p1_d3_ff    <= d1_pay.dist3d;
      p1_lv_ts_ff <= d1_pay.lv_ts;
   end

   // P2: pick the lift scaling divisor, partial products of lift * time
   logic                 p2_vld_ff;
   logic                 use_low, use_lift;
   logic [DUR_W:0]       dsor2_ff;
   logic [DUR_W-1:0]     pp_lo_ff;
   logic [DUR_W-2:0]     pp_hi_ff;
   lms_tail_type         p2_pay_ff;

   always_comb begin
      use_low  = low_ff > rem_ff;
      use_lift = {lift_ff, 1'b0} > {1'b0, rem_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= p1_vld_ff;
      end
      dsor2_ff         <= use_low ? {1'b0, low_ff} : {lift_ff, 1'b0};
      pp_lo_ff         <= DUR_W'(lh_ff) * DUR_W'(rem_ff[31:0]);
      pp_hi_ff         <= (DUR_W-1)'(lh_ff) * (DUR_W-1)'(rem_ff[DUR_W-1:32]);
      p2_pay_ff.nx     <= p1_nx_ff;
      p2_pay_ff.ny     <= p1_ny_ff;
      p2_pay_ff.cz     <= p1_cz_ff;
      p2_pay_ff.tz     <= p1_tz_ff;
      p2_pay_ff.lv_ts  <= p1_lv_ts_ff;
      p2_pay_ff.dist3d <= p1_d3_ff;
      p2_pay_ff.h_div  <= use_low || use_lift;
   end

   // P3: full lift * time product
   logic                p3_vld_ff;
   logic [MULDIV_W-1:0] dend2_ff;
   logic [DUR_W:0]      p3_dsor_ff;
   lms_tail_type        p3_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else begin
         p3_vld_ff <= p2_vld_ff;
      end
      dend2_ff   <= MULDIV_W'(pp_lo_ff) + (MULDIV_W'(pp_hi_ff) << 32);
      p3_dsor_ff <= dsor2_ff;
      p3_pay_ff  <= p2_pay_ff;
   end

   logic                    d2_vld;
   logic [0:0][VEL_W-1:0]   d2_quo;
   lms_tail_type            d2_pay;

   lms_div #(
      .LANES  (1),
      .DEND_W (MULDIV_W),
      .DSOR_W (DUR_W + 1),
      .QW     (VEL_W),
      .PW     ($bits(lms_tail_type))
   ) u_div_lift (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (p3_vld_ff),
      .dend_i (dend2_ff),
      .dsor_i (p3_dsor_ff),
      .pay_i  (p3_pay_ff),
      .vld_o  (d2_vld),
      .quo_o  (d2_quo),
      .pay_o  (d2_pay)
   );

   lms_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .vld_i    (d2_vld),
      .quo_i    (d2_quo[0]),
      .pay_i    (d2_pay),
      .lh_i     (lh_ff),
      .valid_o  (rsp_valid),
      .next_x_o (rsp_next_x),
      .next_y_o (rsp_next_y),
      .next_z_o (rsp_next_z),
      .dist_o   (rsp_distance_left)
   );

endmodule

@@ dv/leg_motion_step_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of leg_motion_step_unit: directed and random steps under several
// register settings, with a scoreboard that predicts each result. Depends on lms_pkg and the RTL.
module leg_motion_step_unit_tb;
   import lms_pkg::*;

   typedef struct {
      logic [31:0] cx, cy, cz, tx, ty, tz;
      logic [23:0] ts;
   } leg_req_type;

   typedef struct {
      logic [31:0] nx, ny, nz, dist_left;
   } leg_rsp_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 200;

   class step_scoreboard;
      leg_rsp_type pending[$];
      longint unsigned planar_vel, lift_h, lift_vel;
      int errors;

      function new();
         planar_vel = 65536;
         lift_h     = 0;
         lift_vel   = 65536;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [VEL_W-1:0] val);
         case (idx)
            CSR_PLANAR_VEL:  planar_vel = val;
            CSR_LIFT_HEIGHT: lift_h     = val;
            CSR_LIFT_VEL:    lift_vel   = val;
            default: ;
         endcase
      endfunction

      function longint unsigned floor_sqrt(logic [127:0] v);
         logic [127:0] rem, trial, root;
         rem  = 0;
         root = 0;
         for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
               rem  = rem - trial;
               root = (root << 1) | 128'd1;
            end else begin
               root = root << 1;
            end
         end
         return root[63:0];
      endfunction

      function longint unsigned scale(longint unsigned a, longint unsigned b,
                                      longint unsigned d);
         logic [127:0] p;
         if (d == 0) return 0;
         p = {64'd0, a} * {64'd0, b};
         p = p / {64'd0, d};
         return p[63:0];
      endfunction

      function longint unsigned travel_time(longint unsigned span, longint unsigned vel);
         longint unsigned q;
         if (vel == 0) return 64'd1 << 62;
         q = (span << LMS_FRAC_BITS) / vel;
         return (q > (64'd1 << 62)) ? (64'd1 << 62) : q;
      endfunction

      function longint unsigned abs64(longint v);
         return (v < 0) ? longint'(-v) : longint'(v);
      endfunction

      function longint axis_move(longint d, longint unsigned stp, longint unsigned d2);
         longint unsigned m;
         m = scale(abs64(d), stp, d2);
         return (d < 0) ? -longint'(m) : longint'(m);
      endfunction

      function leg_rsp_type predict_step(leg_req_type r);
         longint cx, cy, cz, tx, ty, tz, dx, dy, dz, nx, ny, nz, lift_dist, th;
         logic [127:0] sq;
         longint unsigned d2, d3, stp, rem_t, up_t, down_t, h, max_z, gap;
         leg_rsp_type o;
         cx = longint'(signed'(r.cx)); cy = longint'(signed'(r.cy));
         cz = longint'(signed'(r.cz)); tx = longint'(signed'(r.tx));
         ty = longint'(signed'(r.ty)); tz = longint'(signed'(r.tz));
         dx = tx - cx; dy = ty - cy; dz = tz - cz;
         sq = {64'd0, abs64(dx)} * {64'd0, abs64(dx)} + {64'd0, abs64(dy)} * {64'd0, abs64(dy)};
         d2 = floor_sqrt(sq);
         sq = sq + {64'd0, abs64(dz)} * {64'd0, abs64(dz)};
         d3 = floor_sqrt(sq);
         stp = (planar_vel * r.ts) >> LMS_FRAC_BITS;
         if (d2 < stp) stp = d2;
         nx = cx; ny = cy; nz = cz;
         if (d2 != 0) begin
            nx = cx + axis_move(dx, stp, d2);
            ny = cy + axis_move(dy, stp, d2);
         end
         rem_t     = travel_time(d2, planar_vel);
         lift_dist = dz + longint'(lift_h);
         up_t      = travel_time(abs64(lift_dist), lift_vel);
         down_t    = travel_time(lift_h, lift_vel);
         h = lift_h;
         if (2 * up_t > rem_t) h = scale(lift_h, rem_t, 2 * up_t);
         if (down_t > rem_t) h = scale(lift_h, rem_t, down_t);
         th    = tz + longint'(h);
         max_z = (lift_vel * r.ts) >> LMS_FRAC_BITS;
         gap   = abs64(th - cz);
         if (gap < max_z) max_z = gap;
         if (cz < th) nz = cz + longint'(max_z);
         else if (cz > th) nz = cz - longint'(max_z);
         if (nz > 64'sd2147483647) nz = 64'sd2147483647;
         if (nz < -64'sd2147483648) nz = -64'sd2147483648;
         o.nx        = nx[31:0];
         o.ny        = ny[31:0];
         o.nz        = nz[31:0];
         o.dist_left = (d3 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d3[31:0];
         return o;
      endfunction

      function void note_request(leg_req_type r);
         pending.push_back(predict_step(r));
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
         errors++;
      endtask

      task check_response(leg_rsp_type got);
         leg_rsp_type want;
         if (pending.size() == 0) begin
            report("unexpected response", got.nx, 32'd0);
            return;
         end
         want = pending.pop_front();
         if (got.nx !== want.nx) report("next_x", got.nx, want.nx);
         if (got.ny !== want.ny) report("next_y", got.ny, want.ny);
         if (got.nz !== want.nz) report("next_z", got.nz, want.nz);
         if (got.dist_left !== want.dist_left)
            report("distance_left", got.dist_left, want.dist_left);
      endtask
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   logic [POS_W-1:0]     req_current_x = 0, req_current_y = 0, req_current_z = 0;
   logic [POS_W-1:0]     req_target_x = 0, req_target_y = 0, req_target_z = 0;
   logic [TS_W-1:0]      req_time_step = 0;
   logic                 rsp_valid;
   logic [POS_W-1:0]     rsp_next_x, rsp_next_y, rsp_next_z, rsp_distance_left;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PLANAR_VEL;
   logic [VEL_W-1:0]     csr_wdata = 0;

   step_scoreboard sb = new();
   int             quiet_cycles = 0;
   int             sender_idle_pct = 0;

   always #5 clock = ~clock;

   leg_motion_step_unit uut (.*);

   always @(posedge clock) begin
      leg_rsp_type got;
      if (!reset && rsp_valid) begin
         got.nx        = rsp_next_x;
         got.ny        = rsp_next_y;
         got.nz        = rsp_next_z;
         got.dist_left = rsp_distance_left;
         sb.check_response(got);
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [VEL_W-1:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task send_step(leg_req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start         <= 1;
      req_current_x <= r.cx; req_current_y <= r.cy; req_current_z <= r.cz;
      req_target_x  <= r.tx; req_target_y  <= r.ty; req_target_z  <= r.tz;
      req_time_step <= r.ts;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
   endtask

   task wait_drained();
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function logic [31:0] near(logic [31:0] base);
      return base + ($signed($urandom) >>> $urandom_range(31, 6));
   endfunction

   function logic [31:0] corner();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function leg_req_type random_step();
      leg_req_type r;
      int mode;
      mode = $urandom_range(9);
      r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
      r.ts = TS_W'($urandom >> $urandom_range(8, 31));
      if (mode <= 3) begin
         r.cx = $signed($urandom) >>> $urandom_range(0, 12);
         r.cy = $signed($urandom) >>> $urandom_range(0, 12);
         r.cz = $signed($urandom) >>> $urandom_range(0, 12);
         r.tx = near(r.cx); r.ty = near(r.cy); r.tz = near(r.cz);
      end else if (mode <= 6) begin
         r.tx = $urandom; r.ty = $urandom; r.tz = $urandom;
         r.ts = TS_W'($urandom);
      end else if (mode == 7) begin
         r.tx = r.cx; r.ty = r.cy; r.tz = near(r.cz);
      end else if (mode == 8) begin
         r.cx = corner(); r.cy = corner(); r.cz = corner();
         r.tx = corner(); r.ty = corner(); r.tz = corner();
         r.ts = $urandom_range(1) ? 24'hFF_FFFF : TS_W'($urandom);
      end else begin
         // Z near the top or bottom of the range
         r.cz = $urandom_range(1) ? 32'h7FFF_0000 + $urandom_range(65535)
                                  : 32'h8000_0000 + $urandom_range(65535);
         r.tz = r.cz + ($signed($urandom) >>> 16);
         r.tx = near(r.cx); r.ty = near(r.cy);
         r.ts = TS_W'($urandom);
      end
      return r;
   endfunction

   task directed_steps();
      leg_req_type r;
      logic [31:0] pos[4];
      pos = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      foreach (pos[i]) begin
         r = '{pos[i], pos[i], pos[i], pos[i], pos[i], pos[i], 24'hFF_FFFF};
         send_step(r);
      end
      // full-scale span on all axes: distance saturates
      send_step('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF});
      send_step('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h0});
      // same XY, Z moves
      send_step('{32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0002_0000,
                  32'h0005_0000, 24'h00_8000});
      // Z near the top and the bottom of its range, where it may clamp
      send_step('{32'h0, 32'h0, 32'h7FFF_F000, 32'h0010_0000, 32'h0, 32'h7FFF_FFFF,
                  24'hFF_FFFF});
      send_step('{32'h0, 32'h0, 32'h8000_1000, 32'h0010_0000, 32'h0, 32'h8000_0000,
                  24'hFF_FFFF});
      send_step('{32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h0, 24'h01_0000});
      send_step('{32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1, 24'h00_0001});
   endtask

   task run_phase(int idle_pct, int count, logic [VEL_W-1:0] pv, logic [VEL_W-1:0] lh,
                  logic [VEL_W-1:0] lv);
      wait_drained();
      write_reg(CSR_PLANAR_VEL, pv);
      write_reg(CSR_LIFT_HEIGHT, lh);
      write_reg(CSR_LIFT_VEL, lv);
      write_reg(2'd3, VEL_W'($urandom));   // unmapped index, must be ignored
      sender_idle_pct = idle_pct;
      directed_steps();
      repeat (count) send_step(random_step());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      sender_idle_pct = 0;
      directed_steps();
      repeat (200) send_step(random_step());
      run_phase(69, 250, 31'h0, 31'h7FFF_FFFF, 31'h0);
      run_phase(0, 250, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      run_phase(34, 250, 31'h0002_0000, 31'h0004_0000, 31'h0000_8000);
      run_phase(0, 250, VEL_W'($urandom >> $urandom_range(1, 20)),
                VEL_W'($urandom >> $urandom_range(1, 20)),
                VEL_W'($urandom >> $urandom_range(1, 20)));
      run_phase(69, 200, 31'h1, 31'h0010_0000, 31'h7FFF_FFFF);
      run_phase(34, 200, 31'h0001_0000, 31'h0, 31'h0001_0000);
      wait_drained();
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/lms_pkg.sv
rtl/lms_front.sv
rtl/lms_sqrt.sv
rtl/lms_div.sv
rtl/lms_back.sv
rtl/leg_motion_step_unit.sv
dv/leg_motion_step_unit_tb.sv
